// ===== src/vad_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and constants for the vector angle pipeline
// no dependencies; imported by every module of the block
package vad_pkg;

    localparam int ITERATIONS    = 16;
    localparam int FRACTION_BITS = 7;
    localparam int ANG_FRAC      = 24;
    localparam int VEC_SCALE     = 20;
    localparam int TABLE_LEN     = 24;

    localparam int NUM_ITER = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int VEC_PAD = 3;
    localparam int VEC_W   = VEC_PAD + DIFF_W + VEC_SCALE;
    localparam int ANG_W   = ANG_FRAC + 10;
    localparam int RSHIFT  = ANG_FRAC - FRACTION_BITS;
    localparam int R_W     = ANG_W - RSHIFT;

    localparam logic [ANG_W-1:0] Z_HALF     = ANG_W'(64'd180 << ANG_FRAC);
    localparam logic [ANG_W-1:0] Z_FULL     = ANG_W'(64'd360 << ANG_FRAC);
    localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(64'd1 << (RSHIFT - 1));
    localparam logic [R_W-1:0]   LIMIT      = R_W'(64'd360 << FRACTION_BITS);

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234683,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } vec_t;

endpackage

// ===== src/vad_prep.sv =====
`timescale 1ns / 1ps
// input stage: coordinate differences, left half plane fold, scaling
// depends on vad_pkg
module vad_prep import vad_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    input  logic                      next_accept,
    output logic                      accept,
    output logic                      vld,
    output vec_t                      vec
);

    logic                     v_reg;
    vec_t                     vec_reg;
    vec_t                     vec_next;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] fx;
    logic signed [DIFF_W-1:0] fy;
    logic                     flip;

    always_comb
    begin
        dx   = DIFF_W'(target_x) - DIFF_W'(origin_x);
        dy   = DIFF_W'(target_y) - DIFF_W'(origin_y);
        flip = dx[DIFF_W-1];
        fx   = flip ? -dx : dx;
        fy   = flip ? -dy : dy;
        vec_next.x    = {{VEC_PAD{fx[DIFF_W-1]}}, fx, {VEC_SCALE{1'b0}}};
        vec_next.y    = {{VEC_PAD{fy[DIFF_W-1]}}, fy, {VEC_SCALE{1'b0}}};
        vec_next.z    = flip ? Z_HALF : '0;
        vec_next.zero = (dx == '0) && (dy == '0);
    end

    assign accept = !v_reg || next_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (accept)
        begin
            v_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vld = v_reg;
    assign vec = vec_reg;

endmodule

// ===== src/vad_cordic.sv =====
`timescale 1ns / 1ps
// vectoring cordic, one registered stage per iteration
// depends on vad_pkg
module vad_cordic import vad_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic vld_in,
    input  vec_t vec_in,
    input  logic next_accept,
    output logic accept,
    output logic vld,
    output vec_t vec
);

    logic [NUM_ITER:0]   en;
    logic [NUM_ITER-1:0] v_arr;
    vec_t                st_arr [NUM_ITER];

    assign en[NUM_ITER] = next_accept;

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        vec_t                    src;
        vec_t                    res;
        logic                    src_v;
        logic                    v_reg;
        vec_t                    st_reg;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [ANG_W-1:0] ang;

        if (i == 0)
        begin : g_first
            assign src   = vec_in;
            assign src_v = vld_in;
        end
        else
        begin : g_rest
            assign src   = st_arr[i-1];
            assign src_v = v_arr[i-1];
        end

        assign xs  = src.x >>> i;
        assign ys  = src.y >>> i;
        assign ang = ANG_W'(ATAN_TABLE[i]);

        always_comb
        begin
            res.zero = src.zero;
            if (!src.y[VEC_W-1] && (src.y != '0))
            begin
                res.x = src.x + ys;
                res.y = src.y - xs;
                res.z = src.z + ang;
            end
            else
            begin
                res.x = src.x - ys;
                res.y = src.y + xs;
                res.z = src.z - ang;
            end
        end

        assign en[i] = !v_reg || en[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en[i])
            begin
                v_reg <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i] && src_v)
            begin
                st_reg <= res;
            end
        end

        assign v_arr[i]  = v_reg;
        assign st_arr[i] = st_reg;
    end

    assign accept = en[0];
    assign vld    = v_arr[NUM_ITER-1];
    assign vec    = st_arr[NUM_ITER-1];

endmodule

// ===== src/vad_finish.sv =====
`timescale 1ns / 1ps
// output stages: wrap negative angle, round, wrap at 360, output register
// depends on vad_pkg
module vad_finish import vad_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  vec_t               vec_in,
    input  logic               angle_stall,
    output logic               accept,
    output logic               angle_valid,
    output logic [ANGLE_W-1:0] angle_deg
);

    logic               va_reg;
    logic               vb_reg;
    logic               vc_reg;
    logic               en_a;
    logic               en_b;
    logic               en_c;
    logic [ANG_W-1:0]   za_reg;
    logic [ANG_W-1:0]   za_next;
    logic               zero_a_reg;
    logic [R_W-1:0]     r_reg;
    logic [R_W-1:0]     r_next;
    logic [ANG_W-1:0]   sum;
    logic               zero_b_reg;
    logic [R_W-1:0]     wrapped;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_next;

    assign en_c = !vc_reg || !angle_stall;
    assign en_b = !vb_reg || en_c;
    assign en_a = !va_reg || en_b;

    always_comb
    begin
        za_next    = vec_in.z[ANG_W-1] ? (vec_in.z + Z_FULL) : vec_in.z;
        sum        = za_reg + ROUND_HALF;
        r_next     = sum[ANG_W-1:RSHIFT];
        wrapped    = (r_reg >= LIMIT) ? (r_reg - LIMIT) : r_reg;
        angle_next = zero_b_reg ? '0 : ANGLE_W'(wrapped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= vld_in;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && vld_in)
        begin
            za_reg     <= za_next;
            zero_a_reg <= vec_in.zero;
        end
        if (en_b && va_reg)
        begin
            r_reg      <= r_next;
            zero_b_reg <= zero_a_reg;
        end
        if (en_c && vb_reg)
        begin
            angle_reg <= angle_next;
        end
    end

    assign accept      = en_a;
    assign angle_valid = vc_reg;
    assign angle_deg   = angle_reg;

endmodule

// ===== src/vector_angle_degrees.sv =====
`timescale 1ns / 1ps
// top level of the vector angle pipeline
// depends on vad_pkg, vad_prep, vad_cordic, vad_finish
//
// Gives the direction from origin to target in degrees, 0 up to but not
// including 360, unsigned with 7 fraction bits; equal points give 0. The block
// is a fully pipelined vectoring cordic: one register stage for the
// differences, one per cordic iteration (16), and three for wrap, rounding
// and the output register. One point pair is taken every cycle unless
// pair_stall is high. Every stage has its own valid bit and advances when it
// is empty or the stage after it advances, so empty slots close up while the
// output is stalled; the input stalls only once all 20 stages hold an item.
module vector_angle_degrees import vad_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pair_valid,
    output logic                      pair_stall,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    output logic                      angle_valid,
    input  logic                      angle_stall,
    output logic [ANGLE_W-1:0]        angle_deg
);

    logic prep_accept;
    logic prep_vld;
    vec_t prep_vec;
    logic cordic_accept;
    logic cordic_vld;
    vec_t cordic_vec;
    logic finish_accept;

    vad_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (pair_valid),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .next_accept (cordic_accept),
        .accept      (prep_accept),
        .vld         (prep_vld),
        .vec         (prep_vec)
    );

    vad_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .vld_in      (prep_vld),
        .vec_in      (prep_vec),
        .next_accept (finish_accept),
        .accept      (cordic_accept),
        .vld         (cordic_vld),
        .vec         (cordic_vec)
    );

    vad_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .vld_in      (cordic_vld),
        .vec_in      (cordic_vec),
        .angle_stall (angle_stall),
        .accept      (finish_accept),
        .angle_valid (angle_valid),
        .angle_deg   (angle_deg)
    );

    assign pair_stall = !prep_accept;

endmodule

// ===== bench/angle_checker.sv =====
`timescale 1ns / 1ps
// checker for the vector angle block: watches both channels, predicts each angle
// and compares it with the angle that comes out; depends on vad_pkg

module angle_checker import vad_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pair_valid,
    input  logic                      pair_stall,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    input  logic                      angle_valid,
    input  logic                      angle_stall,
    input  logic [ANGLE_W-1:0]        angle_deg,
    output int                        fail_count,
    output int                        in_flight
);

    localparam int ATAN_STEPS = 24;
    localparam int CORDIC_STEPS = (ITERATIONS < ATAN_STEPS) ? ITERATIONS : ATAN_STEPS;
    localparam int DROP_BITS = ANG_FRAC - FRACTION_BITS;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_DEG [ATAN_STEPS] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234683, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic [ANGLE_W-1:0] angle_fifo [$];

    function automatic logic [ANGLE_W-1:0] predict_angle(
        input logic signed [COORD_W-1:0] ox,
        input logic signed [COORD_W-1:0] oy,
        input logic signed [COORD_W-1:0] tx,
        input logic signed [COORD_W-1:0] ty
    );
        longint dx;
        longint dy;
        longint vx;
        longint vy;
        longint acc;
        longint sx;
        longint sy;
        longint rounded;
        dx = longint'(tx) - longint'(ox);
        dy = longint'(ty) - longint'(oy);
        if (dx == 0 && dy == 0)
        begin
            return '0;
        end
        vx = dx * (longint'(1) << VEC_SCALE);
        vy = dy * (longint'(1) << VEC_SCALE);
        acc = 0;
        // left half plane: mirror the vector and start from 180 degrees
        if (dx < 0)
        begin
            vx = -vx;
            vy = -vy;
            acc = longint'(180) << ANG_FRAC;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0)
            begin
                vx = vx + sy;
                vy = vy - sx;
                acc = acc + ATAN_DEG[i];
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
                acc = acc - ATAN_DEG[i];
            end
        end
        if (acc < 0)
        begin
            acc = acc + (longint'(360) << ANG_FRAC);
        end
        rounded = (acc + (longint'(1) << (DROP_BITS - 1))) >>> DROP_BITS;
        // a value that rounds up to a full turn wraps to zero
        if (rounded >= (longint'(360) << FRACTION_BITS))
        begin
            rounded = rounded - (longint'(360) << FRACTION_BITS);
        end
        return rounded[ANGLE_W-1:0];
    endfunction

    initial
    begin
        fail_count = 0;
        in_flight = 0;
    end

    always @(posedge clk)
    begin
        logic [ANGLE_W-1:0] wanted;
        if (rst_n)
        begin
            if (angle_valid && !angle_stall)
            begin
                if (angle_fifo.size() == 0)
                begin
                    $error("angle_deg: expected none, actual %0d", angle_deg);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    wanted = angle_fifo.pop_front();
                    if (angle_deg !== wanted)
                    begin
                        $error("angle_deg: expected %0d, actual %0d", wanted, angle_deg);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (pair_valid && !pair_stall)
            begin
                angle_fifo.push_back(predict_angle(origin_x, origin_y, target_x, target_y));
            end
            in_flight <= angle_fifo.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for vector_angle_degrees: clock, reset, point pair stimulus,
// output stall pattern and verdict; depends on vad_pkg and angle_checker

module tb_top;
    import vad_pkg::*;

    localparam int RANDOM_PAIRS = 600;
    localparam int SEGMENT = 50;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pair_valid = 1'b0;
    logic                      pair_stall;
    logic signed [COORD_W-1:0] origin_x = '0;
    logic signed [COORD_W-1:0] origin_y = '0;
    logic signed [COORD_W-1:0] target_x = '0;
    logic signed [COORD_W-1:0] target_y = '0;
    logic                      angle_valid;
    logic                      angle_stall = 1'b0;
    logic [ANGLE_W-1:0]        angle_deg;
    int                        fail_count;
    int                        in_flight;
    int                        cycles = 0;
    bit                        steady = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vector_angle_degrees i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle_deg   (angle_deg)
    );

    angle_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle_deg   (angle_deg),
        .fail_count  (fail_count),
        .in_flight   (in_flight)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_pair(
        input logic signed [COORD_W-1:0] ox,
        input logic signed [COORD_W-1:0] oy,
        input logic signed [COORD_W-1:0] tx,
        input logic signed [COORD_W-1:0] ty
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        origin_x <= ox;
        origin_y <= oy;
        target_x <= tx;
        target_y <= ty;
        do @(posedge clk); while (pair_stall);
    endtask

    task automatic wait_all_angles();
        pair_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic send_random_pair();
        int kind;
        int ox;
        int oy;
        int mag;
        int sx;
        int sy;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            send_pair(COORD_W'($urandom()), COORD_W'($urandom()),
                      COORD_W'($urandom()), COORD_W'($urandom()));
        end
        else if (kind <= 7)
        begin
            // short vectors around a random origin
            ox = $urandom_range(0, 60000) - 30000;
            oy = $urandom_range(0, 60000) - 30000;
            send_pair(COORD_W'(ox), COORD_W'(oy),
                      COORD_W'(ox + $urandom_range(0, 100) - 50),
                      COORD_W'(oy + $urandom_range(0, 100) - 50));
        end
        else if (kind == 8)
        begin
            // axis and diagonal directions, or equal points when both signs are zero
            ox = $urandom_range(0, 24000) - 12000;
            oy = $urandom_range(0, 24000) - 12000;
            mag = $urandom_range(1, 20000);
            sx = $urandom_range(0, 2) - 1;
            sy = $urandom_range(0, 2) - 1;
            send_pair(COORD_W'(ox), COORD_W'(oy),
                      COORD_W'(ox + sx * mag), COORD_W'(oy + sy * mag));
        end
        else
        begin
            ox = $urandom();
            oy = $urandom();
            send_pair(COORD_W'(ox), COORD_W'(oy), COORD_W'(ox), COORD_W'(oy));
        end
    endtask

    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                angle_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            angle_stall <= 1'b0;
            do @(posedge clk); while (!angle_valid);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // equal points, axes, diagonals, extremes and the wrap near a full turn
        send_pair(0, 0, 0, 0);
        send_pair(-32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, 32767);
        send_pair(0, 0, 100, 0);
        send_pair(0, 0, 0, 100);
        send_pair(0, 0, -100, 0);
        send_pair(0, 0, 0, -100);
        send_pair(0, 0, 100, 100);
        send_pair(-32768, 0, 32767, 0);
        send_pair(32767, 0, -32768, 0);
        send_pair(0, -32768, 0, 32767);
        send_pair(0, 32767, 0, -32768);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(-32768, 0, 32767, -1);
        send_pair(32767, 0, -32768, 1);
        send_pair(32767, 1, -32768, 0);
        send_pair(0, 0, 1, -1);
        send_pair(0, 0, -1, 1);
        send_pair(0, 0, -1, -1);
        send_pair(0, 0, 1, 0);
        send_pair(-1, -1, 0, 0);
        send_pair(0, 0, -32768, 32767);
        send_pair(32767, -32768, -32768, 32767);

        for (int k = 0; k < RANDOM_PAIRS; k++)
        begin
            if (k % SEGMENT == 0)
            begin
                steady = ((k / SEGMENT) % 4 == 3);
            end
            if (k == RANDOM_PAIRS / 2)
            begin
                wait_all_angles();
            end
            send_random_pair();
        end

        wait_all_angles();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
